// ===== design/gga_pkg.sv =====
// Shared types and constants for the GGA sentence field extractor.
// No dependencies; used by every module of the block.
package gga_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned FIELD_COUNT_W = 4;
   localparam int unsigned LENGTH_W      = 8;
   localparam int unsigned TAG_POS_W     = 3;
   localparam int unsigned MODE_W        = 2;

   localparam int unsigned DEF_MAX_CAPTURE = 127;

   localparam logic [FIELD_COUNT_W-1:0] FIELD_COUNT_RESET = 4'd8;

   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_G      = 8'h47;
   localparam logic [BYTE_W-1:0] CHAR_P      = 8'h50;
   localparam logic [BYTE_W-1:0] CHAR_A      = 8'h41;

   localparam logic [TAG_POS_W-1:0] TAG_LEN = 3'd5;

   // One finished response from the parser.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              truncated;
   } rsp_type;

   // Expected tag "GPGGA", one character per position.
   function automatic logic [BYTE_W-1:0] tag_char(input logic [TAG_POS_W-1:0] pos);
      logic [BYTE_W-1:0] c;
      case (pos)
         3'd0:    c = CHAR_G;
         3'd1:    c = CHAR_P;
         3'd2:    c = CHAR_G;
         3'd3:    c = CHAR_G;
         3'd4:    c = CHAR_A;
         default: c = CHAR_G;
      endcase
      return c;
   endfunction

endpackage

// ===== design/gga_parser.sv =====
// Sentence parser: tag matching, field comma counting and capture limit.
// Depends on gga_pkg. Produces at most one response per processed byte.
module gga_parser #(
   parameter int unsigned MAX_CAPTURE = gga_pkg::DEF_MAX_CAPTURE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [gga_pkg::FIELD_COUNT_W-1:0]    field_count,
   input  logic                                 item_valid,
   input  logic [gga_pkg::BYTE_W-1:0]           item_byte,
   output gga_pkg::rsp_type                     result
);
   import gga_pkg::*;

   localparam logic [MODE_W-1:0] MODE_WAIT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TAG  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DATA = 2'd2;

   localparam logic [LENGTH_W-1:0] CAP_LIMIT = LENGTH_W'(MAX_CAPTURE);

   logic [MODE_W-1:0]        mode_ff,     mode_in;
   logic [TAG_POS_W-1:0]     tag_pos_ff,  tag_pos_in;
   logic                     mismatch_ff, mismatch_in;
   logic [FIELD_COUNT_W-1:0] commas_ff,   commas_in;
   logic [LENGTH_W-1:0]      length_ff,   length_in;
   logic                     dropped_ff,  dropped_in;

   logic is_comma;

   assign is_comma = (item_byte == CHAR_COMMA);

   always_comb begin
      mode_in     = mode_ff;
      tag_pos_in  = tag_pos_ff;
      mismatch_in = mismatch_ff;
      commas_in   = commas_ff;
      length_in   = length_ff;
      dropped_in  = dropped_ff;
      result      = '0;

      case (mode_ff)
         MODE_TAG: begin
            if (is_comma) begin
               mode_in     = (!mismatch_ff && tag_pos_ff == TAG_LEN) ? MODE_DATA : MODE_WAIT;
               tag_pos_in  = '0;
               mismatch_in = 1'b0;
               commas_in   = '0;
               length_in   = '0;
               dropped_in  = 1'b0;
            end else if (tag_pos_ff >= TAG_LEN) begin
               mismatch_in = 1'b1;
            end else begin
               if (item_byte != tag_char(tag_pos_ff)) begin
                  mismatch_in = 1'b1;
               end
               tag_pos_in = tag_pos_ff + 3'd1;
            end
         end
         MODE_DATA: begin
            if (is_comma && commas_ff >= field_count) begin
               result.valid     = 1'b1;
               result.last      = 1'b1;
               result.truncated = dropped_ff;
               mode_in          = MODE_WAIT;
               tag_pos_in       = '0;
               mismatch_in      = 1'b0;
               commas_in        = '0;
               length_in        = '0;
               dropped_in       = 1'b0;
            end else begin
               if (is_comma) begin
                  commas_in = commas_ff + 4'd1;
               end
               if (length_ff < CAP_LIMIT) begin
                  length_in    = length_ff + 8'd1;
                  result.valid = 1'b1;
                  result.data  = item_byte;
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         default: begin
            // The unused mode code behaves like waiting for a dollar sign.
            if (item_byte == CHAR_DOLLAR) begin
               mode_in     = MODE_TAG;
               tag_pos_in  = '0;
               mismatch_in = 1'b0;
               commas_in   = '0;
               length_in   = '0;
               dropped_in  = 1'b0;
            end else begin
               mode_in = MODE_WAIT;
            end
         end
      endcase

      if (!item_valid) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_WAIT;
         tag_pos_ff  <= '0;
         mismatch_ff <= 1'b0;
         commas_ff   <= '0;
         length_ff   <= '0;
         dropped_ff  <= 1'b0;
      end else if (item_valid) begin
         mode_ff     <= mode_in;
         tag_pos_ff  <= tag_pos_in;
         mismatch_ff <= mismatch_in;
         commas_ff   <= commas_in;
         length_ff   <= length_in;
         dropped_ff  <= dropped_in;
      end
   end

endmodule

// ===== design/gga_rsp_reg.sv =====
// Response output register with stream handshake toward the receiver.
// Depends on gga_pkg for the response struct.
module gga_rsp_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  gga_pkg::rsp_type            result,
   output logic                        load_ok,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [gga_pkg::BYTE_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);
   import gga_pkg::*;

   logic              valid_ff;
   logic [BYTE_W-1:0] data_ff;
   logic              last_ff;
   logic              trunc_ff;

   // The slot can take a new response when empty or being drained now.
   assign load_ok = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_ok) begin
         valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok && result.valid) begin
         data_ff  <= result.data;
         last_ff  <= result.last;
         trunc_ff <= result.truncated;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = trunc_ff;

endmodule

// ===== design/gga_sentence_field_extractor.sv =====
// Top level of the GGA sentence field extractor.
// Depends on gga_pkg, gga_parser and gga_rsp_reg.
//
// Usage:
//   The req_ channel takes one received character per request on req_tdata.
//   After a '$' and the tag GPGGA followed by a comma, every later character
//   is sent out on the rsp_ channel (rsp_tdata), inner commas included, until
//   the comma after field_count inner commas. That comma yields one response
//   with rsp_tlast high and rsp_tdata zero; rsp_tuser then tells whether
//   characters beyond MAX_CAPTURE were dropped. Other sentences give nothing.
//   csr_wr_en / csr_wr_data set field_count (reset value 8) while idle.
// Timing:
//   A request is held in an input register, then parsed into the response
//   register that drives rsp_tvalid. One request per cycle is sustained
//   while rsp_tready stays high: the single response register is refilled
//   in the same cycle that the receiver takes its content.
//   When the receiver stalls, the input register holds one more request and
//   req_tready drops until the response register drains.
//   Synchronous reset empties both registers, sets field_count to 8 and
//   returns the parser to waiting for '$'.
module gga_sentence_field_extractor #(
   parameter int unsigned MAX_CAPTURE = gga_pkg::DEF_MAX_CAPTURE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [gga_pkg::FIELD_COUNT_W-1:0]   csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gga_pkg::BYTE_W-1:0]          req_tdata,   // [7:0] in_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gga_pkg::BYTE_W-1:0]          rsp_tdata,   // [7:0] out_byte
   output logic                                rsp_tlast,   // sentence_end
   output logic                                rsp_tuser    // [0] truncated
);
   import gga_pkg::*;

   logic [FIELD_COUNT_W-1:0] field_count_ff;
   logic                     in_valid_ff;
   logic [BYTE_W-1:0]        in_byte_ff;
   logic                     load_ok;
   logic                     advance;
   rsp_type                  result;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_count_ff <= FIELD_COUNT_RESET;
      end else if (csr_wr_en) begin
         field_count_ff <= csr_wr_data;
      end
   end

   assign advance    = in_valid_ff && load_ok;
   assign req_tready = !in_valid_ff || load_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   gga_parser #(
      .MAX_CAPTURE (MAX_CAPTURE)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .field_count (field_count_ff),
      .item_valid  (advance),
      .item_byte   (in_byte_ff),
      .result      (result)
   );

   gga_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Truncation is only ever reported on the sentence end response.
   a_trunc_only_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tuser)
      else $error("truncated flag set on a streamed character");

   // The sentence end response carries a zero character.
   a_end_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == '0)
      else $error("sentence end response with nonzero data");

   // A held request in the input register is never lost or overwritten.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !load_ok |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a pending request");

endmodule

// ===== test/gga_checker.sv =====
// Response checker for the GGA sentence field extractor.
// Watches the request, response and CSR ports, predicts every response and compares.
// Depends on gga_pkg.
module gga_checker #(
   parameter int unsigned MAX_CAPTURE = gga_pkg::DEF_MAX_CAPTURE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [gga_pkg::FIELD_COUNT_W-1:0] csr_wr_data,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [gga_pkg::BYTE_W-1:0]        req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [gga_pkg::BYTE_W-1:0]        rsp_tdata,
   input  logic                              rsp_tlast,
   input  logic                              rsp_tuser,
   output int                                fail_count,
   output int                                pending,
   output int                                byte_count,
   output int                                end_count,
   output int                                trunc_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import gga_pkg::*;

   localparam logic [MODE_W-1:0] MODE_WAIT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TAG  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DATA = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              truncated;
   } sentence_rsp_type;

   // The tag text, first character in the lowest byte.
   localparam logic [5*BYTE_W-1:0] GGA_TAG = {CHAR_A, CHAR_G, CHAR_G, CHAR_P, CHAR_G};

   logic [MODE_W-1:0]        mode;
   logic [TAG_POS_W-1:0]     tag_pos;
   logic                     tag_bad;
   logic [FIELD_COUNT_W-1:0] commas;
   logic [LENGTH_W-1:0]      cap_len;
   logic                     dropped;
   logic [FIELD_COUNT_W-1:0] field_count;
   sentence_rsp_type         expected_q[$];

   task automatic clear_sentence();
      tag_pos = '0;
      tag_bad = 1'b0;
      commas  = '0;
      cap_len = '0;
      dropped = 1'b0;
   endtask

   task automatic stream_byte(input logic [BYTE_W-1:0] b);
      if (cap_len < MAX_CAPTURE) begin
         cap_len++;
         expected_q.push_back('{data: b, last: 1'b0, truncated: 1'b0});
         byte_count++;
      end else begin
         dropped = 1'b1;
      end
   endtask

   task automatic parse_byte(input logic [BYTE_W-1:0] b);
      logic tag_ok;
      case (mode)
         MODE_TAG: begin
            if (b == CHAR_COMMA) begin
               tag_ok = !tag_bad && tag_pos == TAG_LEN;
               clear_sentence();
               mode = tag_ok ? MODE_DATA : MODE_WAIT;
            end else if (tag_pos >= TAG_LEN) begin
               tag_bad = 1'b1;
            end else begin
               if (b != GGA_TAG[tag_pos*BYTE_W +: BYTE_W])
                  tag_bad = 1'b1;
               tag_pos++;
            end
         end
         MODE_DATA: begin
            if (b == CHAR_COMMA && commas >= field_count) begin
               expected_q.push_back('{data: '0, last: 1'b1, truncated: dropped});
               end_count++;
               if (dropped)
                  trunc_count++;
               clear_sentence();
               mode = MODE_WAIT;
            end else begin
               if (b == CHAR_COMMA)
                  commas++;
               stream_byte(b);
            end
         end
         // The spare mode code behaves like waiting for a dollar.
         default: begin
            if (b == CHAR_DOLLAR) begin
               clear_sentence();
               mode = MODE_TAG;
            end else begin
               mode = MODE_WAIT;
            end
         end
      endcase
   endtask

   task automatic check_field(input string what, input logic [BYTE_W-1:0] want_v,
                              input logic [BYTE_W-1:0] got_v);
      if (got_v !== want_v) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : watch
      sentence_rsp_type want;
      if (reset) begin
         mode        = MODE_WAIT;
         field_count = FIELD_COUNT_RESET;
         clear_sentence();
         expected_q.delete();
         fail_count  = 0;
         byte_count  = 0;
         end_count   = 0;
         trunc_count = 0;
      end else begin
         // Compare before predicting so a stray response cannot hide behind
         // an expectation pushed at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, data %0h last %b user %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = expected_q.pop_front();
               check_field("out_byte", want.data, rsp_tdata);
               check_field("sentence_end", BYTE_W'(want.last), BYTE_W'(rsp_tlast));
               check_field("truncated", BYTE_W'(want.truncated), BYTE_W'(rsp_tuser));
            end
         end
         if (csr_wr_en)
            field_count = csr_wr_data;
         if (req_tvalid && req_tready)
            parse_byte(req_tdata);
      end
      pending = expected_q.size();
   end

endmodule

// ===== test/tb_top.sv =====
// Top of the GGA sentence field extractor testbench: clock, reset, stimulus, verdict.
// Depends on gga_pkg, gga_sentence_field_extractor and gga_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gga_pkg::*;

   localparam int ITEMS        = 2000;
   localparam int PHASES       = 7;
   localparam int DRAIN_CYCLES = 4;
   localparam int LONG_HOLD    = 200;
   localparam int LIMIT        = 200000;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     csr_wr_en   = 1'b0;
   logic [FIELD_COUNT_W-1:0] csr_wr_data = '0;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [BYTE_W-1:0]        req_tdata   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [BYTE_W-1:0]        rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tuser;

   int   fail_count, pending, byte_count, end_count, trunc_count;
   int   sent_items    = 0;
   int   ignored_items = 0;
   int   burst_left    = 0;
   logic sender_gaps   = 1'b1;
   logic hold_off_go   = 1'b0;

   gga_sentence_field_extractor dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   gga_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .pending     (pending),
      .byte_count  (byte_count),
      .end_count   (end_count),
      .trunc_count (trunc_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < LIMIT; cycles++)
         @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Receiver: segments of always-ready, half-ready and mostly-stalled
   // cycles, plus one long hold-off once the stimulus asks for it.
   initial begin : receiver
      int seg_left;
      int seg_mode;
      int held;
      seg_left = 0;
      seg_mode = 0;
      held     = 0;
      forever begin
         @(negedge clock);
         if (hold_off_go && held < LONG_HOLD) begin
            held++;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(16, 96);
               seg_mode = $urandom_range(0, 2);
            end
            seg_left--;
            case (seg_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the request
   // was taken, with req_tvalid still high so a following byte goes back to back.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = sender_gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      burst_left--;
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      foreach (s[i])
         send_byte(s[i]);
   endtask

   task automatic send_header(input string tag);
      send_byte(CHAR_DOLLAR);
      send_text(tag);
      send_byte(CHAR_COMMA);
   endtask

   task automatic send_field(input int len);
      logic [BYTE_W-1:0] b;
      repeat (len) begin
         do
            b = BYTE_W'($urandom_range(0, 255));
         while (b == CHAR_COMMA);
         send_byte(b);
      end
   endtask

   task automatic write_field_count(input logic [FIELD_COUNT_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      // A tag byte gives no response, so let the pipeline empty as well.
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random_unit(input int field_count);
      int    pick;
      int    long_field;
      int    fields;
      int    tag_len;
      int    first;
      string gga;
      logic [BYTE_W-1:0] c;
      gga  = "GPGGA";
      pick = $urandom_range(0, 99);
      long_field = ($urandom_range(0, 7) == 0) ? $urandom_range(0, field_count) : -1;
      if (pick < 75) begin
         // Matching sentence; two in fifteen of these stop before the closing comma.
         send_header(gga);
         fields = (pick < 65) ? field_count + 1 : $urandom_range(0, field_count);
         for (int f = 0; f < fields; f++) begin
            send_field(f == long_field ? $urandom_range(128, 170) : $urandom_range(0, 5));
            send_byte(CHAR_COMMA);
         end
         if (pick >= 65)
            send_field($urandom_range(0, 5));
      end else if (pick < 90) begin
         // Tag that is usually damaged: wrong length or wrong characters.
         send_byte(CHAR_DOLLAR);
         tag_len = $urandom_range(0, 7);
         for (int p = 0; p < tag_len; p++) begin
            if (p < 5 && $urandom_range(0, 3) != 0) begin
               c = gga[p];
            end else begin
               do
                  c = BYTE_W'($urandom_range(0, 255));
               while (c == CHAR_COMMA);
            end
            send_byte(c);
         end
         send_byte(CHAR_COMMA);
      end else begin
         first = sent_items;
         repeat ($urandom_range(1, 8))
            send_byte(BYTE_W'($urandom_range(0, 255)));
         ignored_items += sent_items - first;
      end
   endtask

   initial begin : stimulus
      logic [FIELD_COUNT_W-1:0] plan [PHASES];
      int quota;
      int start;
      plan[0] = 4'd15;
      plan[1] = 4'd1;
      plan[2] = 4'd8;
      for (int p = 3; p < PHASES; p++)
         plan[p] = FIELD_COUNT_W'($urandom_range(0, 15));
      quota = ITEMS / PHASES;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero field count, extreme bytes, a dollar inside the data,
      // then a short and a long tag.
      write_field_count(4'd0);
      send_header("GPGGA");
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_COMMA);
      send_header("GPGG");
      send_header("GPGGAA");

      for (int p = 0; p < PHASES; p++) begin
         write_field_count(plan[p]);
         if (p == 1)
            hold_off_go <= 1'b1;
         sender_gaps = (p != 2);
         start = sent_items - ignored_items;
         while (sent_items - ignored_items - start < quota)
            send_random_unit(plan[p]);
      end

      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES * 2) @(negedge clock);

      $display("Run covered %0d requests (%0d outside any sentence) over %0d field counts.",
               sent_items, ignored_items, PHASES + 1);
      $display("Checked %0d streamed bytes and %0d sentence ends, %0d of them truncated.",
               byte_count, end_count, trunc_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
